>>> rtl/cme_pkg.sv
`timescale 1ns / 1ps
package cme_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int SIZE_W    = 11;
  localparam int CTR_W     = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [ADDR_W-1:0] REG_NODE_COUNT   = ADDR_W'(0);
  localparam logic [SIZE_W-1:0] NODE_COUNT_RESET = SIZE_W'(1024);

endpackage

>>> rtl/component_merge_engine.sv
`timescale 1ns / 1ps
// Quick-find connected-components engine.
// Input channel (in_valid/in_ready, node_a, node_b) takes one edge word at a
// time. Output channel (out_valid/out_ready) returns one word per edge:
// did_merge, group_size of node_a's component, and all_joined when that size
// equals node_count. node_count sits at APB byte address 0 (reset 1024).
// Per-node labels and per-label sizes live in two RAMs with registered reads.
// States per edge, from accept to result load:
//   no merge (same component): S_RD_A, S_RD_B, S_CNT_A, S_DONE.
//   merge: adds S_CNT_B and S_WALK; the label RAM is walked one entry a cycle
//   and every entry carrying node_b's label is rewritten to node_a's label.
// One edge is in flight at a time; the next edge is taken the cycle after the
// previous result has been loaded into the output register.
// Reset: a clearing pass writes each label to its own index and each size to
// one; in_ready stays low during that pass while the APB port is served as
// usual.
// A stalled receiver holds the result in the output register; the block then
// waits at the end of the next edge until that register is free.
module component_merge_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [9:0]                          node_a,
  input  logic [9:0]                          node_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                did_merge,
  output logic [cme_pkg::SIZE_W-1:0]          group_size,
  output logic                                all_joined,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cme_pkg::ADDR_W-1:0]          paddr,
  input  logic [cme_pkg::DATA_W-1:0]          pwdata,
  output logic [cme_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CNT_B,
    S_CNT_A,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;

  logic [cme_pkg::SIZE_W-1:0] node_count;

  logic [cme_pkg::NODE_W-1:0] label_mem [cme_pkg::MAX_NODES];
  logic [cme_pkg::SIZE_W-1:0] count_mem [cme_pkg::MAX_NODES];

  logic [cme_pkg::NODE_W-1:0] lbl_raddr;
  logic [cme_pkg::NODE_W-1:0] lbl_rdata;
  logic                       lbl_we;
  logic [cme_pkg::NODE_W-1:0] lbl_waddr;
  logic [cme_pkg::NODE_W-1:0] lbl_wdata;

  logic [cme_pkg::NODE_W-1:0] cnt_raddr;
  logic [cme_pkg::SIZE_W-1:0] cnt_rdata;
  logic                       cnt_we;
  logic [cme_pkg::NODE_W-1:0] cnt_waddr;
  logic [cme_pkg::SIZE_W-1:0] cnt_wdata;

  logic [cme_pkg::CTR_W-1:0]  ctr;
  logic                       walk_pend;
  logic [cme_pkg::NODE_W-1:0] walk_addr;
  logic [cme_pkg::NODE_W-1:0] b_idx;
  logic [cme_pkg::NODE_W-1:0] la;
  logic [cme_pkg::NODE_W-1:0] lb;
  logic [cme_pkg::SIZE_W-1:0] cb;
  logic [cme_pkg::SIZE_W-1:0] size;
  logic                       merge;
  logic                       out_free;

  // APB register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= cme_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == cme_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[cme_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == cme_pkg::REG_NODE_COUNT) begin
      prdata = cme_pkg::DATA_W'(node_count);
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (lbl_we) begin
      label_mem[lbl_waddr] <= lbl_wdata;
    end
    lbl_rdata <= label_mem[lbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= count_mem[cnt_raddr];
  end

  // Memory port control
  always_comb begin
    lbl_raddr = '0;
    lbl_we    = 1'b0;
    lbl_waddr = '0;
    lbl_wdata = '0;
    cnt_raddr = '0;
    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        lbl_we    = 1'b1;
        lbl_waddr = ctr[cme_pkg::NODE_W-1:0];
        lbl_wdata = ctr[cme_pkg::NODE_W-1:0];
        cnt_we    = 1'b1;
        cnt_waddr = ctr[cme_pkg::NODE_W-1:0];
        cnt_wdata = cme_pkg::SIZE_W'(1);
      end
      S_IDLE: begin
        lbl_raddr = node_a[cme_pkg::NODE_W-1:0];
      end
      S_RD_A: begin
        lbl_raddr = b_idx;
      end
      S_RD_B: begin
        // same label: fetch the size of node_a's component, else node_b's first
        cnt_raddr = (lbl_rdata == la) ? la : lbl_rdata;
      end
      S_CNT_B: begin
        cnt_we    = 1'b1;
        cnt_waddr = lb;
        cnt_wdata = '0;
        cnt_raddr = la;
      end
      S_CNT_A: begin
        if (merge) begin
          cnt_we    = 1'b1;
          cnt_waddr = la;
          cnt_wdata = cme_pkg::SIZE_W'(cnt_rdata + cb);
        end
      end
      S_WALK: begin
        lbl_raddr = ctr[cme_pkg::NODE_W-1:0];
        if (walk_pend && lbl_rdata == lb) begin
          lbl_we    = 1'b1;
          lbl_waddr = walk_addr;
          lbl_wdata = la;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ctr       <= '0;
      walk_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (ctr == cme_pkg::CTR_W'(cme_pkg::MAX_NODES - 1)) begin
            ctr   <= '0;
            state <= S_IDLE;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            b_idx <= node_b[cme_pkg::NODE_W-1:0];
            state <= S_RD_A;
          end
        end
        S_RD_A: begin
          la    <= lbl_rdata;
          state <= S_RD_B;
        end
        S_RD_B: begin
          lb <= lbl_rdata;
          if (lbl_rdata == la) begin
            merge <= 1'b0;
            cb    <= '0;
            state <= S_CNT_A;
          end else begin
            merge <= 1'b1;
            state <= S_CNT_B;
          end
        end
        S_CNT_B: begin
          cb    <= cnt_rdata;
          state <= S_CNT_A;
        end
        S_CNT_A: begin
          size <= cme_pkg::SIZE_W'(cnt_rdata + cb);
          if (merge) begin
            ctr       <= '0;
            walk_pend <= 1'b0;
            state     <= S_WALK;
          end else begin
            state <= S_DONE;
          end
        end
        S_WALK: begin
          // read one label a cycle, rewrite the previous one if it matches
          if (ctr != cme_pkg::CTR_W'(cme_pkg::MAX_NODES)) begin
            walk_pend <= 1'b1;
            walk_addr <= ctr[cme_pkg::NODE_W-1:0];
            ctr       <= ctr + 1'b1;
          end else begin
            walk_pend <= 1'b0;
            if (walk_pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_valid  <= 1'b1;
            did_merge  <= merge;
            group_size <= size;
            all_joined <= (size == node_count);
            state      <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_edge: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("edge accepted while another is in flight");

  a_size_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> group_size != '0)
    else $error("reported component has zero size");

  a_merge_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && did_merge |-> group_size >= cme_pkg::SIZE_W'(2))
    else $error("merged component smaller than two");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready && !out_valid)
    else $error("block active during clearing pass");
`endif

endmodule
